@@ rtl/core/gfti_pkg.sv @@
package gfti_pkg;

	localparam int SPACE_DIMS          = 3;
	localparam int MAX_POINTS_PER_AXIS = 32;
	localparam int STORE_DEPTH         = 32768;
	localparam int ADDR_W              = 15;
	localparam int SAMPLE_W            = 16;
	localparam int VALUE_W             = 48;
	localparam int PTS_W               = 6;
	localparam int IDX_W               = $clog2(MAX_POINTS_PER_AXIS);
	localparam int CFG_IDX_W           = 3;
	localparam int NCORNERS            = 1 << SPACE_DIMS;
	localparam int CORNER_W            = (SPACE_DIMS > 1) ? SPACE_DIMS : 1;

	localparam logic [VALUE_W-1:0] V48_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] V48_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINTS_X = 3'd0,
		REG_POINTS_Y = 3'd1,
		REG_POINTS_Z = 3'd2,
		REG_INV_X    = 3'd3,
		REG_INV_Y    = 3'd4,
		REG_INV_Z    = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef struct packed {
		logic                   kind;
		logic [ADDR_W-1:0]      sample_index;
		logic signed [15:0]     sample_value;
		logic signed [31:0]     rel_x;
		logic signed [31:0]     rel_y;
		logic signed [31:0]     rel_z;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      outside;
	} out_item_t;

	// blend control handed from the sequencer to the arithmetic unit
	typedef struct packed {
		logic        start;
		logic        first;   // first axis: base*65536, no shift
	} blend_ctl_t;

endpackage

@@ rtl/core/gfti_if.sv @@
interface gfti_in_if import gfti_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface gfti_out_if import gfti_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface gfti_cfg_if import gfti_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/core/grid_field_trilinear_interpolator.sv @@
// Channel  | Dir | Payload
// ---------+-----+--------------------------------------------------
// req      | in  | kind, sample_index, sample_value, rel_x/y/z
// rsp      | out | value (48b signed), outside
// cfg      | in  | index (3b), wdata (32b)
//
// A write request is taken and ready stays high after it.
// A query holds ready low from when it is taken until its response is loaded:
// three axis passes through the scale unit, eight single-port store reads,
// a state to land the last read, seven blends through the shared multiply
// unit, and a state to load the response.
// Reset clears control and sets the config registers to their defaults; the store is not cleared.
// A waiting response does not block the next request being taken; a query
// that finishes while it still waits holds in its last state until it drains.
module grid_field_trilinear_interpolator import gfti_pkg::*; (
	input logic clk,
	input logic arst_n,
	gfti_in_if.sink    req,
	gfti_out_if.source rsp,
	gfti_cfg_if.sink   cfg
);
	typedef enum logic [3:0] {
		S_IDLE, S_AXIS, S_AXWAIT, S_AXSAVE, S_ADDR, S_READ, S_BLEND, S_BWAIT, S_OUT
	} state_t;

	state_t                    state_q;
	logic [PTS_W-1:0]          pts_q [3];
	logic [31:0]               inv_q [3];
	in_item_t                  item_q;
	logic [1:0]                ax_q;
	logic [IDX_W-1:0]          lo_q [3], up_q [3];
	logic signed [49:0]        wt_q [3];
	logic                      outside_q;
	logic [CORNER_W:0]         cnt_q;
	logic signed [VALUE_W-1:0] v_q [NCORNERS];
	logic [CORNER_W-1:0]       bcnt_q;
	logic [1:0]                bax_q;
	logic                      rd_pend_q;
	logic [CORNER_W-1:0]       rd_slot_q;

	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_addr;
	logic [SAMPLE_W-1:0]       ram_rdata;
	logic [PTS_W-1:0]          peff [3];
	logic [IDX_W-1:0]          ax_lo, ax_up;
	logic signed [49:0]        ax_wt;
	logic                      ax_cl;
	logic signed [31:0]        ax_rel;
	logic [IDX_W-1:0]          cx, cy, cz;
	logic [ADDR_W+12:0]        lin;
	blend_ctl_t                bctl;
	logic                      bdone;
	logic signed [VALUE_W-1:0] bres, bbase;
	logic signed [VALUE_W:0]   bd;
	logic [CORNER_W-1:0]       bi;

	// clamp points into 1..MAX
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (pts_q[a] == '0)
				peff[a] = PTS_W'(1);
			else if (pts_q[a] > PTS_W'(MAX_POINTS_PER_AXIS))
				peff[a] = PTS_W'(MAX_POINTS_PER_AXIS);
			else
				peff[a] = pts_q[a];
		end
	end

	// the response register parts a waiting response from the request side
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	always_comb begin
		case (ax_q)
			2'd0:    ax_rel = item_q.rel_x;
			2'd1:    ax_rel = item_q.rel_y;
			default: ax_rel = item_q.rel_z;
		endcase
	end

	gfti_axis u_axis (
		.clk(clk), .start(state_q == S_AXIS), .rel(ax_rel), .inv(inv_q[ax_q]),
		.pts(peff[ax_q]), .lo_idx(ax_lo), .up_idx(ax_up), .wt(ax_wt), .clamped(ax_cl)
	);

	// corner address; each product is narrow (a 5b index times 6b point counts)
	always_comb begin
		cx  = cnt_q[0] ? up_q[0] : lo_q[0];
		cy  = (CORNER_W > 1 && cnt_q[1]) ? up_q[1] : lo_q[1];
		cz  = (CORNER_W > 2 && cnt_q[CORNER_W-1]) ? up_q[2] : lo_q[2];
		lin = (ADDR_W+13)'(cx);
		if (SPACE_DIMS > 1) lin = lin + (ADDR_W+13)'(cy * peff[0]);
		if (SPACE_DIMS > 2) lin = lin + (ADDR_W+13)'(cz * (peff[0] * peff[1]));
	end

	assign ram_we   = req.valid && req.ready && req.data.kind == KIND_WRITE;
	assign ram_addr = ram_we ? req.data.sample_index : lin[ADDR_W-1:0];

	gfti_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_store (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(req.data.sample_value),
		.rdata(ram_rdata)
	);

	// blend operands: pair 2i, 2i+1 -> slot i; the difference needs one extra bit
	assign bi    = CORNER_W'({bcnt_q, 1'b0});
	assign bbase = (bax_q == 2'd0) ? (v_q[bi] <<< 16) : v_q[bi];
	assign bd    = (VALUE_W+1)'(v_q[bi + 1'b1]) - (VALUE_W+1)'(v_q[bi]);
	assign bctl.start = (state_q == S_BLEND);
	assign bctl.first = (bax_q == 2'd0);

	gfti_blend u_blend (
		.clk(clk), .arst_n(arst_n), .ctl(bctl), .base(bbase), .d(bd),
		.t(wt_q[bax_q]), .done(bdone), .result(bres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp.valid <= 1'b0;
			rd_pend_q <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				pts_q[a] <= PTS_W'(32);
				inv_q[a] <= 32'd65536;
			end
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_POINTS_X: pts_q[0] <= cfg.wdata[PTS_W-1:0];
					REG_POINTS_Y: pts_q[1] <= cfg.wdata[PTS_W-1:0];
					REG_POINTS_Z: pts_q[2] <= cfg.wdata[PTS_W-1:0];
					REG_INV_X:    inv_q[0] <= cfg.wdata;
					REG_INV_Y:    inv_q[1] <= cfg.wdata;
					REG_INV_Z:    inv_q[2] <= cfg.wdata;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready)
				rsp.valid <= 1'b0;
			rd_pend_q <= 1'b0;
			if (rd_pend_q)
				v_q[rd_slot_q] <= VALUE_W'(signed'(ram_rdata));
			case (state_q)
				S_IDLE: if (req.valid && req.ready && req.data.kind == KIND_QUERY) begin
					item_q    <= req.data;
					ax_q      <= '0;
					outside_q <= 1'b0;
					for (int a = 0; a < 3; a++) begin
						lo_q[a] <= '0; up_q[a] <= '0; wt_q[a] <= '0;
					end
					state_q <= S_AXIS;
				end
				S_AXIS: state_q <= S_AXWAIT;
				S_AXWAIT: state_q <= S_AXSAVE;
				S_AXSAVE: begin
					lo_q[ax_q] <= ax_lo;
					up_q[ax_q] <= ax_up;
					wt_q[ax_q] <= ax_wt;
					outside_q  <= outside_q | ax_cl;
					if (ax_q == 2'(SPACE_DIMS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_ADDR;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_AXIS;
					end
				end
				S_ADDR: begin
					// one store read per cycle
					rd_pend_q <= 1'b1;
					rd_slot_q <= CORNER_W'(cnt_q);
					cnt_q     <= cnt_q + 1'b1;
					if (cnt_q == (CORNER_W+1)'(NCORNERS - 1))
						state_q <= S_READ;
				end
				S_READ: begin
					bcnt_q  <= '0;
					bax_q   <= '0;
					state_q <= S_BLEND;
				end
				S_BLEND: state_q <= S_BWAIT;
				S_BWAIT: if (bdone) begin
					v_q[bcnt_q] <= bres;
					if (32'(bcnt_q) + 1 == (NCORNERS >> (bax_q + 1))) begin
						bcnt_q <= '0;
						if (bax_q == 2'(SPACE_DIMS - 1))
							state_q <= S_OUT;
						else begin
							bax_q   <= bax_q + 2'd1;
							state_q <= S_BLEND;
						end
					end else begin
						bcnt_q  <= bcnt_q + 1'b1;
						state_q <= S_BLEND;
					end
				end
				S_OUT: if (!rsp.valid || rsp.ready) begin
					rsp.valid            <= 1'b1;
					rsp.data.value       <= v_q[0];
					rsp.data.outside     <= outside_q;
					state_q              <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/gfti_ram.sv @@
module gfti_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

@@ rtl/core/gfti_blend.sv @@
// base + floor(d*t / 2^sh), saturated to 48 bits. Four partial products, then shift/add.
module gfti_blend import gfti_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  blend_ctl_t                ctl,
	input  logic signed [VALUE_W-1:0] base,
	input  logic signed [VALUE_W:0]   d,
	input  logic signed [49:0]        t,
	output logic                      done,
	output logic signed [VALUE_W-1:0] result
);
	// d and t cut into 25-bit halves: four 26x26 products, one per cycle
	logic signed [49:0]        d_q, t_q;
	logic signed [VALUE_W-1:0] base_q;
	logic                      first_q;
	logic [2:0]                step_q;
	logic                      busy_q;
	logic signed [101:0]       acc_q;
	logic signed [25:0]        da, ta;
	logic signed [51:0]        pp;
	logic signed [101:0]       sh;
	logic signed [101:0]       sum;

	always_comb begin
		da  = step_q[0] ? {d_q[49], d_q[49:25]} : {1'b0, d_q[24:0]};
		ta  = step_q[1] ? {t_q[49], t_q[49:25]} : {1'b0, t_q[24:0]};
		pp  = da * ta;
		// floor by arithmetic shift, then saturate on 62-bit magnitude rule
		sh  = first_q ? acc_q : (acc_q >>> 16);
		sum = 102'(base_q) + sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q  <= 1'b1;
				step_q  <= '0;
				d_q     <= 50'(d);
				t_q     <= t;
				base_q  <= base;
				first_q <= ctl.first;
				acc_q   <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				case (step_q)
					3'd0:       acc_q <= 102'(pp);
					3'd1, 3'd2: acc_q <= acc_q + (102'(pp) <<< 25);
					3'd3:       acc_q <= acc_q + (102'(pp) <<< 50);
					default: begin
						busy_q <= 1'b0;
						done   <= 1'b1;
						if (sh >= 102'sh4000000000000000 || sh < -102'sh4000000000000000)
							result <= sh[101] ? V48_MIN : V48_MAX;
						else if (sum > 102'(signed'(V48_MAX)))
							result <= V48_MAX;
						else if (sum < 102'(signed'(V48_MIN)))
							result <= V48_MIN;
						else
							result <= sum[VALUE_W-1:0];
					end
				endcase
			end
		end
	end
endmodule

@@ rtl/core/gfti_axis.sv @@
// Per-axis scale, floor, clamp, weight. One axis per start; the product, then the outputs, are registered.
module gfti_axis import gfti_pkg::*; (
	input  logic               clk,
	input  logic               start,
	input  logic signed [31:0] rel,
	input  logic [31:0]        inv,
	input  logic [PTS_W-1:0]   pts,
	output logic [IDX_W-1:0]   lo_idx,
	output logic [IDX_W-1:0]   up_idx,
	output logic signed [49:0] wt,
	output logic               clamped
);
	logic signed [64:0] s_q;
	logic [PTS_W-1:0]   p_q;
	logic signed [32:0] ifl;
	logic signed [48:0] f16;
	logic [PTS_W-1:0]   ic;
	logic               lo_c, hi_c;

	always_comb begin
		ifl  = 33'(s_q >>> 32);
		f16  = 49'(s_q >>> 16);
		lo_c = ifl < 0;
		hi_c = !lo_c && ifl >= 33'(p_q);
		ic   = lo_c ? '0 : (hi_c ? p_q - 1'b1 : PTS_W'(ifl));
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= 65'(rel * $signed({1'b0, inv}));
			p_q <= pts;
		end
		lo_idx  <= IDX_W'(ic);
		up_idx  <= (ic + 1'b1 >= p_q) ? '0 : IDX_W'(ic + 1'b1);
		wt      <= 50'(f16) - 50'($signed({1'b0, ic, 16'h0}));
		clamped <= lo_c || hi_c;
	end
endmodule

@@ rtl/core/gfti_checker.sv @@
module gfti_props import gfti_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic req_kind,
	input logic rsp_valid,
	input logic rsp_ready
);
	ap_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");
	ap_query_no_immediate: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_kind == KIND_QUERY |=> !req_ready)
		else $error("ready during query");
	ap_write_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid && req_valid && req_ready && req_kind == KIND_WRITE |=> !rsp_valid)
		else $error("response after write");
endmodule

bind grid_field_trilinear_interpolator gfti_props u_props (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.req_kind(req.data.kind), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
);

@@ sim/gfti_checker.sv @@
`timescale 1ns / 100ps

module gfti_checker import gfti_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gfti_in_if   req,
	gfti_out_if  rsp,
	gfti_cfg_if  cfg,
	output int   errors,
	output int   pending
);

	typedef logic signed [127:0] wide_t;

	localparam wide_t PROD_LIM = 128'sh4000_0000_0000_0000;
	localparam wide_t VMAX     = 128'sh7FFF_FFFF_FFFF;
	localparam wide_t VMIN     = -128'sh8000_0000_0000;

	logic [SAMPLE_W-1:0] samples [STORE_DEPTH];
	logic [PTS_W-1:0]    pts_cfg [3];
	logic [31:0]         inv_cfg [3];
	out_item_t           expected_q [$];

	// base + floor(d * t / 2^sh), saturated
	function automatic wide_t lerp_step(wide_t base, wide_t d, wide_t t, int sh);
		wide_t p;
		p = (d * t) >>> sh;
		if (p >= PROD_LIM)
			return (d * t < 0) ? VMIN : VMAX;
		if (p <= -PROD_LIM)
			return VMIN;
		p = base + p;
		if (p > VMAX) return VMAX;
		if (p < VMIN) return VMIN;
		return p;
	endfunction

	function automatic out_item_t interp(in_item_t q);
		logic signed [31:0] r [3];
		longint s, i, pe [3], lo [3], up [3], w [3], lin, x, y, z;
		wide_t v [8];
		logic out_flag;
		out_item_t o;
		int n;
		r[0] = q.rel_x;
		r[1] = q.rel_y;
		r[2] = q.rel_z;
		out_flag = 1'b0;
		for (int a = 0; a < 3; a++) begin
			pe[a] = pts_cfg[a];
			if (pe[a] < 1) pe[a] = 1;
			if (pe[a] > MAX_POINTS_PER_AXIS) pe[a] = MAX_POINTS_PER_AXIS;
			s = longint'(r[a]) * longint'({32'b0, inv_cfg[a]});
			i = s >>> 32;
			if (i < 0) begin
				i = 0;
				out_flag = 1'b1;
			end else if (i >= pe[a]) begin
				i = pe[a] - 1;
				out_flag = 1'b1;
			end
			lo[a] = i;
			up[a] = (i + 1 >= pe[a]) ? 0 : i + 1;
			w[a]  = (s >>> 16) - i * 65536;
		end
		for (int c = 0; c < 8; c++) begin
			x = c[0] ? up[0] : lo[0];
			y = c[1] ? up[1] : lo[1];
			z = c[2] ? up[2] : lo[2];
			lin = x + y * pe[0] + z * pe[0] * pe[1];
			v[c] = wide_t'($signed(samples[lin[ADDR_W-1:0]]));
		end
		n = 8;
		for (int a = 0; a < 3; a++) begin
			n = n >> 1;
			for (int c = 0; c < n; c++) begin
				if (a == 0)
					v[c] = lerp_step(v[2*c] * 65536, v[2*c+1] - v[2*c], w[0], 0);
				else
					v[c] = lerp_step(v[2*c], v[2*c+1] - v[2*c], w[a], 16);
			end
		end
		o.value   = v[0][VALUE_W-1:0];
		o.outside = out_flag;
		return o;
	endfunction

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				pts_cfg[a] = 6'd32;
				inv_cfg[a] = 32'd65536;
			end
		end else begin
			// response first: it belongs to an older query
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: response with no query waiting: value=%h outside=%b",
							$realtime, rsp.data.value, rsp.data.outside);
				end else begin
					e = expected_q.pop_front();
					if (rsp.data.value !== e.value || rsp.data.outside !== e.outside) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch exp value=%h outside=%b got value=%h outside=%b",
								$realtime, e.value, e.outside, rsp.data.value,
								rsp.data.outside);
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.data.kind == KIND_WRITE)
					samples[req.data.sample_index] = req.data.sample_value;
				else
					expected_q.push_back(interp(req.data));
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index <= REG_POINTS_Z)
					pts_cfg[cfg.index] = cfg.wdata[PTS_W-1:0];
				else if (cfg.index <= REG_INV_Z)
					inv_cfg[cfg.index - REG_INV_X] = cfg.wdata;
			end
		end
		pending = expected_q.size();
	end

endmodule

@@ sim/grid_field_trilinear_interpolator_tb.sv @@
`timescale 1ns / 100ps

module grid_field_trilinear_interpolator_tb;
	import gfti_pkg::*;

	// the limit covers a query plus the longest stall on each side
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN      = 100;
	localparam int ITEMS      = 950;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;

	gfti_in_if  req ();
	gfti_out_if rsp ();
	gfti_cfg_if cfg ();

	grid_field_trilinear_interpolator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	gfti_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg     (cfg),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// handshakes seen at the rising edge, read back at the falling edge
	logic req_fire, cfg_fire;
	always @(posedge clk) begin
		req_fire <= req.valid && req.ready;
		cfg_fire <= cfg.valid && cfg.ready;
	end

	// watchdog: cycles with no request, response or config accepted
	int quiet;
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("[grid_field_trilinear_interpolator] ERROR");
			$finish;
		end
	end

	// no idling on either side once calm is set
	logic calm;
	int   stall_left;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp.ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			rsp.ready  <= 1'b0;
			stall_left <= $urandom_range(0, 17);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// shadow of the grid setting, used to aim query locations and to find the corners a query reads
	int     grid_pts [3];
	longint grid_inv [3];

	// store entries written so far, and requests taken
	bit     written [STORE_DEPTH];
	int     sent;

	task automatic send_request(in_item_t it);
		if (!calm && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= it;
		do @(negedge clk); while (!req_fire);
		if (it.kind == KIND_WRITE)
			written[it.sample_index] = 1'b1;
		sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= val;
		do @(negedge clk); while (!cfg_fire);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	// block idle: all responses in, and any write request has settled
	task automatic wait_idle();
		req.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// upper bits of the points registers are junk on purpose
	task automatic set_grid(int px, int py, int pz, longint ix, longint iy, longint iz);
		wait_idle();
		write_reg(REG_POINTS_X, {$urandom} << 6 | px[5:0]);
		write_reg(REG_POINTS_Y, {$urandom} << 6 | py[5:0]);
		write_reg(REG_POINTS_Z, {$urandom} << 6 | pz[5:0]);
		write_reg(REG_INV_X, ix[31:0]);
		write_reg(REG_INV_Y, iy[31:0]);
		write_reg(REG_INV_Z, iz[31:0]);
		// indices past the list are dropped by the block
		if ($urandom_range(0, 1))
			write_reg(CFG_IDX_W'(REG_INV_Z + 1 + $urandom_range(0, 1)), $urandom);
		grid_pts[0] = px[5:0];
		grid_pts[1] = py[5:0];
		grid_pts[2] = pz[5:0];
		grid_inv[0] = ix[31:0];
		grid_inv[1] = iy[31:0];
		grid_inv[2] = iz[31:0];
	endtask

	// location whose cell index lands around -1..P+1, sometimes anywhere
	function automatic logic [31:0] aim(int a);
		longint pe, tgt, r;
		pe = grid_pts[a];
		if (pe < 1) pe = 1;
		if (pe > MAX_POINTS_PER_AXIS) pe = MAX_POINTS_PER_AXIS;
		if (grid_inv[a] == 0 || $urandom_range(0, 5) == 0)
			return $urandom;
		tgt = (longint'($urandom_range(0, (pe + 2) * 256)) - 256) <<< 24;
		tgt = tgt + longint'($urandom_range(0, 255)) * 65536;
		r = tgt / grid_inv[a];
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic logic [15:0] any_sample();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t write_item(logic [ADDR_W-1:0] idx, logic [15:0] val);
		in_item_t it;
		it              = {$urandom, $urandom, $urandom, $urandom};
		it.kind         = KIND_WRITE;
		it.sample_index = idx;
		it.sample_value = val;
		return it;
	endfunction

	function automatic in_item_t query_item(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		in_item_t it;
		it       = {$urandom, $urandom, $urandom, $urandom};
		it.kind  = KIND_QUERY;
		it.rel_x = x;
		it.rel_y = y;
		it.rel_z = z;
		return it;
	endfunction

	// write any corner the query will read that holds no sample yet, then query
	task automatic send_query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		logic [31:0] r [3];
		longint      pe [3], lo [3], up [3], s, i, lin;
		r[0] = x;
		r[1] = y;
		r[2] = z;
		for (int a = 0; a < 3; a++) begin
			pe[a] = grid_pts[a];
			if (pe[a] < 1) pe[a] = 1;
			if (pe[a] > MAX_POINTS_PER_AXIS) pe[a] = MAX_POINTS_PER_AXIS;
			s = longint'(signed'(r[a])) * grid_inv[a];
			i = s >>> 32;
			if (i < 0) i = 0;
			else if (i >= pe[a]) i = pe[a] - 1;
			lo[a] = i;
			up[a] = (i + 1 >= pe[a]) ? 0 : i + 1;
		end
		for (int c = 0; c < 8; c++) begin
			lin = (c[0] ? up[0] : lo[0]) + (c[1] ? up[1] : lo[1]) * pe[0]
				+ (c[2] ? up[2] : lo[2]) * pe[0] * pe[1];
			if (!written[lin[ADDR_W-1:0]])
				send_request(write_item(lin[ADDR_W-1:0], any_sample()));
		end
		send_request(query_item(x, y, z));
	endtask

	function automatic longint any_inv();
		case ($urandom_range(0, 7))
			0: return 1;
			1: return 32'hFFFF_FFFF;
			2: return 0;
			3: return 65536;
			4: return $urandom_range(1, 262144);
			default: return $urandom;
		endcase
	endfunction

	function automatic int any_pts();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 32;
			3: return $urandom_range(33, 63);
			default: return $urandom_range(2, 32);
		endcase
	endfunction

	initial begin
		int first_sent;
		arst_n     = 1'b0;
		calm       = 1'b0;
		stall_left = 0;
		quiet      = 0;
		req.valid  = 1'b0;
		req.data   = '0;
		cfg.valid  = 1'b0;
		cfg.index  = '0;
		cfg.wdata  = '0;
		rsp.ready  = 1'b0;
		for (int a = 0; a < 3; a++) begin
			grid_pts[a] = 32;
			grid_inv[a] = 65536;
		end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset grid: edges, outside on each side, extremes
		send_request(write_item(15'd0, 16'h7FFF));
		send_request(write_item(15'd1, 16'h8000));
		send_request(write_item(15'h7FFF, 16'h8000));
		send_query(32'h0, 32'h0, 32'h0);
		send_query(32'h0000_8000, 32'h0001_4000, 32'h0002_C000);
		send_query(32'hFFFF_FFFF, 32'h0, 32'h0);
		send_query(32'h0020_0000, 32'h001F_FFFF, 32'h001F_8000);
		send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_query(32'h001F_C000, 32'h001F_C000, 32'h001F_C000);
		// huge weights push the blends into saturation
		set_grid(32, 32, 32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_query(32'h7FFF_FFFF, 32'h0, 32'h0);
		send_query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_query(32'h0000_0001, 32'h0, 32'h0);
		// smallest grid, tiny spacing, zero spacing, oversized point counts
		set_grid(1, 1, 1, 1, 1, 1);
		send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		send_query(32'h0, 32'h0, 32'h0);
		set_grid(0, 63, 40, 0, 65536, 0);
		send_query(32'h1234_5678, 32'h0021_0000, 32'h8000_0000);
		send_query(32'hFFFF_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
		send_request(write_item(15'd31, 16'h7FFF));
		send_query(32'h0, 32'h001F_8000, 32'h0);

		// random phases, the last one without idling
		first_sent = sent;
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: set_grid(1, 1, 1, 1, 1, 1);
				1: set_grid(32, 32, 32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: set_grid(32, 32, 32, 65536, 65536, 65536);
				default: set_grid(any_pts(), any_pts(), any_pts(), any_inv(), any_inv(),
					any_inv());
			endcase
			if (ph == 9) calm = 1'b1;
			while (sent < first_sent + (ITEMS - first_sent) * (ph + 1) / 10) begin
				if ($urandom_range(0, 9) < 3)
					send_request(write_item(ADDR_W'($urandom), any_sample()));
				else
					send_query(aim(0), aim(1), aim(2));
			end
		end

		req.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (errors == 0)
			$display("[grid_field_trilinear_interpolator] OK");
		else
			$display("[grid_field_trilinear_interpolator] ERROR");
		$finish;
	end

endmodule
